[sv/hcmm_pkg.sv]
// Shared types, constants and address decode functions for the handheld console memory map.
// Used by hcmm_ctrl and by the top level; no other dependencies.
package hcmm_pkg;

    localparam int BOOT_ROM_BYTES = 256;
    localparam int ROM_BANK_BYTES = 16384;
    localparam int DMA_LENGTH     = 160;
    localparam int CART_BYTES     = 2 * ROM_BANK_BYTES;

    // One physical byte memory holds every store
    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = 16;

    // Bus map boundaries
    localparam logic [15:0] ROM_END       = 16'h7FFF;
    localparam logic [15:0] WRAM_END      = 16'hDFFF;
    localparam logic [15:0] ECHO_END      = 16'hFDFF;
    localparam logic [15:0] SPRITE_END    = 16'hFE9F;
    localparam logic [15:0] HOLE_END      = 16'hFEFF;
    localparam logic [15:0] ECHO_OFFSET   = 16'h2000;
    localparam logic [15:0] BOOT_OFF_ADDR = 16'h0100;
    localparam logic [15:0] DIV_ADDR      = 16'hFF04;
    localparam logic [15:0] STAT_ADDR     = 16'hFF41;
    localparam logic [15:0] DMA_ADDR      = 16'hFF46;
    localparam logic [7:0]  STAT_TAKE     = 8'hF8;
    localparam logic [7:0]  STAT_KEEP     = 8'h07;

    // Physical placement of the stores that do not sit at their bus address:
    // the boot store lives in the echo window, which is never stored itself.
    localparam logic [15:0] BOOT_BASE   = 16'hE000;
    localparam logic [15:0] SPRITE_BASE = 16'hFE00;

    typedef enum logic [1:0] {
        MODE_READ      = 2'd0,
        MODE_WRITE     = 2'd1,
        MODE_LOAD_CART = 2'd2,
        MODE_LOAD_BOOT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        WR_IGNORE,
        WR_PLAIN,
        WR_ZERO,
        WR_STAT,
        WR_DMA
    } wr_kind_t;

    typedef struct packed {
        logic [15:0] phys;
        logic        zero;
        logic        finish;
    } rd_map_t;

    typedef struct packed {
        logic [15:0] phys;
        wr_kind_t    kind;
    } wr_map_t;

    // Memory port request from the controller
    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [MEM_AW-1:0] raddr;
    } mem_req_t;

    // Bus read decode: physical address, hole flag, overlay switch-off
    function automatic rd_map_t map_read(input logic [15:0] a, input logic overlay);
        rd_map_t m;
        m.phys   = a;
        m.zero   = 1'b0;
        m.finish = 1'b0;
        if (a <= ROM_END) begin
            if (overlay && (a < 16'(BOOT_ROM_BYTES)))
                m.phys = BOOT_BASE | {8'h00, a[7:0]};
            m.finish = overlay && (a == BOOT_OFF_ADDR);
        end
        else if ((a > WRAM_END) && (a <= ECHO_END)) begin
            m.phys = a - ECHO_OFFSET;
        end
        else if ((a > SPRITE_END) && (a <= HOLE_END)) begin
            m.zero = 1'b1;
        end
        return m;
    endfunction

    // Bus write decode
    function automatic wr_map_t map_write(input logic [15:0] a);
        wr_map_t m;
        m.phys = a;
        if (a <= ROM_END)
            m.kind = WR_IGNORE;
        else if (a <= WRAM_END)
            m.kind = WR_PLAIN;
        else if (a <= ECHO_END)
            m.kind = WR_IGNORE;
        else if (a <= SPRITE_END)
            m.kind = WR_PLAIN;
        else if (a <= HOLE_END)
            m.kind = WR_IGNORE;
        else if (a == DIV_ADDR)
            m.kind = WR_ZERO;
        else if (a == STAT_ADDR)
            m.kind = WR_STAT;
        else if (a == DMA_ADDR)
            m.kind = WR_DMA;
        else
            m.kind = WR_PLAIN;
        return m;
    endfunction

endpackage

[sv/hcmm_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module hcmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/hcmm_ctrl.sv]
// Access sequencer: decodes requests, drives the shared memory, runs the clear
// pass, status read-modify-write and sprite DMA. Depends on hcmm_pkg.
module hcmm_ctrl
    import hcmm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            boot_rom_present,
    input  logic            in_valid,
    output logic            in_ready,
    input  mode_t           in_mode,
    input  logic [15:0]     in_address,
    input  logic [7:0]      in_write_data,
    output mem_req_t        mem_req,
    input  logic [7:0]      mem_rdata,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [7:0]      res_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_ISSUE,
        ST_READ_DATA,
        ST_WRITE,
        ST_STAT_ISSUE,
        ST_STAT_DATA,
        ST_DMA
    } state_t;

    state_t              state_reg;
    logic [15:0]         phys_reg;
    logic [7:0]          data_reg;
    logic                zero_reg;
    logic [MEM_AW-1:0]   raddr_reg;
    logic [MEM_AW-1:0]   clr_cnt_reg;
    logic                boot_finished_reg;
    logic [7:0]          dma_rd_reg;
    logic                p1_valid_reg;
    logic                p1_zero_reg;
    logic [7:0]          p1_idx_reg;
    logic                p2_valid_reg;
    logic                p2_zero_reg;
    logic [7:0]          p2_idx_reg;

    logic                overlay;
    logic                accept;
    rd_map_t             in_rd;
    wr_map_t             in_wr;
    rd_map_t             dma_rd;
    logic                dma_issue;
    logic                dma_done;

    assign overlay   = boot_rom_present && !boot_finished_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_rd     = map_read(in_address, overlay);
    assign in_wr     = map_write(in_address);
    assign dma_rd    = map_read({data_reg, dma_rd_reg}, overlay);
    assign dma_issue = (state_reg == ST_DMA) && (dma_rd_reg < 8'(DMA_LENGTH));
    assign dma_done  = (state_reg == ST_DMA) && !dma_issue && !p1_valid_reg && !p2_valid_reg;

    // Result of a bus read, taken by the output register
    assign res_valid = (state_reg == ST_READ_DATA);
    assign res_data  = zero_reg ? 8'h00 : mem_rdata;

    // Memory port
    always_comb
    begin
        mem_req.raddr = raddr_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = phys_reg;
        mem_req.wdata = data_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = 8'h00;
            end
            ST_WRITE:
                mem_req.we = 1'b1;
            ST_STAT_DATA:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = (data_reg & STAT_TAKE) | (mem_rdata & STAT_KEEP);
            end
            ST_DMA:
            begin
                if (p2_valid_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = SPRITE_BASE | {8'h00, p2_idx_reg};
                    mem_req.wdata = p2_zero_reg ? 8'h00 : mem_rdata;
                end
                else if (dma_done)
                begin
                    // DMA register itself takes the page number last
                    mem_req.we = 1'b1;
                end
            end
            default:
                mem_req.we = 1'b0;
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            boot_finished_reg <= 1'b0;
            dma_rd_reg        <= '0;
            p1_valid_reg      <= 1'b0;
            p2_valid_reg      <= 1'b0;
            zero_reg          <= 1'b0;
        end
        else
        begin
            // DMA read pipeline: address stage, then data stage
            p2_valid_reg <= p1_valid_reg;
            p2_zero_reg  <= p1_zero_reg;
            p2_idx_reg   <= p1_idx_reg;
            p1_valid_reg <= dma_issue;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // Divider register always stores zero
                        data_reg <= ((in_mode == MODE_WRITE) && (in_wr.kind == WR_ZERO)) ?
                                    8'h00 : in_write_data;
                        unique case (in_mode)
                            MODE_READ:
                            begin
                                raddr_reg <= in_rd.phys;
                                zero_reg  <= in_rd.zero;
                                if (in_rd.finish)
                                    boot_finished_reg <= 1'b1;
                                state_reg <= ST_READ_ISSUE;
                            end
                            MODE_WRITE:
                            begin
                                phys_reg  <= in_wr.phys;
                                raddr_reg <= in_wr.phys;
                                case (in_wr.kind)
                                    WR_PLAIN: state_reg <= ST_WRITE;
                                    WR_ZERO:  state_reg <= ST_WRITE;
                                    WR_STAT:  state_reg <= ST_STAT_ISSUE;
                                    WR_DMA:
                                    begin
                                        dma_rd_reg <= '0;
                                        state_reg  <= ST_DMA;
                                    end
                                    default:  state_reg <= ST_IDLE;
                                endcase
                            end
                            MODE_LOAD_CART:
                            begin
                                phys_reg <= in_address;
                                if (in_address < 16'(CART_BYTES))
                                    state_reg <= ST_WRITE;
                            end
                            MODE_LOAD_BOOT:
                            begin
                                phys_reg <= BOOT_BASE | {8'h00, in_address[7:0]};
                                if (in_address < 16'(BOOT_ROM_BYTES))
                                    state_reg <= ST_WRITE;
                            end
                        endcase
                    end
                end
                ST_READ_ISSUE:
                    state_reg <= ST_READ_DATA;
                ST_READ_DATA:
                begin
                    // Read address stays put, so the data holds while stalled
                    if (res_ready)
                        state_reg <= ST_IDLE;
                end
                ST_WRITE:
                    state_reg <= ST_IDLE;
                ST_STAT_ISSUE:
                    state_reg <= ST_STAT_DATA;
                ST_STAT_DATA:
                    state_reg <= ST_IDLE;
                ST_DMA:
                begin
                    if (dma_issue)
                    begin
                        raddr_reg   <= dma_rd.phys;
                        p1_zero_reg <= dma_rd.zero;
                        p1_idx_reg  <= dma_rd_reg;
                        dma_rd_reg  <= dma_rd_reg + 1'b1;
                        if (dma_rd.finish)
                            boot_finished_reg <= 1'b1;
                    end
                    if (dma_done)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // No request is taken while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request accepted during clear pass");

    // DMA copies only land in the sprite table, or in the DMA register at the end
    a_dma_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DMA && mem_req.we) |->
            ((mem_req.waddr[15:8] == SPRITE_BASE[15:8] &&
              mem_req.waddr[7:0] < 8'(DMA_LENGTH)) || mem_req.waddr == DMA_ADDR))
        else $error("DMA write outside sprite table");

    // Once the overlay is switched off it stays off
    a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(boot_finished_reg))
        else $error("boot overlay came back");

    // A DMA data stage always follows an address stage
    a_dma_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> $past(p1_valid_reg))
        else $error("DMA data stage without address stage");

    // A result waits until the output side takes it
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("read result dropped");

endmodule

[sv/handheld_console_memory_map_unit.sv]
// Top level of the handheld console memory map: stream ports, config port,
// output register. Depends on hcmm_pkg, hcmm_ctrl and hcmm_ram.
// A bus read passes the read-issue and read-data states, then the output register,
// before it shows on m_tvalid. Requests are taken one at a time, only when idle;
// a DMA write makes 160 copies through the single memory read port before the next.
// Ignored writes and loads return straight to idle.
// Reset: a clearing pass writes all 65536 memory bytes, one per cycle, before
// the first request is accepted; the config register resets to 1.
module handheld_console_memory_map_unit
    import hcmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] read_data
    // Config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              boot_rom_present_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    mem_req_t          mem_req;
    logic [7:0]        mem_rdata;
    logic              res_valid;
    logic              res_ready;
    logic [7:0]        res_data;

    // Config register (one register, word address 0)
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'h0, boot_rom_present_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boot_rom_present_reg <= 1'b1;
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            boot_rom_present_reg <= pwdata[0];
    end

    // Access sequencer
    hcmm_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .boot_rom_present (boot_rom_present_reg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_mode          (mode_t'(s_tuser)),
        .in_address       (s_tdata[15:0]),
        .in_write_data    (s_tdata[23:16]),
        .mem_req          (mem_req),
        .mem_rdata        (mem_rdata),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_data         (res_data)
    );

    // Shared byte memory for all stores
    hcmm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_ready)
            m_tvalid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            m_tdata_reg <= res_data;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
